[rtl/mpsb_pkg.sv]
// Shared constants, types and helper functions for the mip pyramid seen bitmap.
// Depends on nothing; used by the core and its RAM sizing.
package mpsb_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_LEVELS  = 16;
    localparam int MAX_BITS    = 32768;

    localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int UB_W        = STORE_AW + 1;
    localparam int BIT_W       = $clog2(MAX_BITS);

    // Fixed field widths of the ports
    localparam int OP_W        = 3;
    localparam int LVL_IN_W    = 6;
    localparam int COORD_W     = 9;
    localparam int SIDE_W      = 8;
    localparam int LEVEL_W     = 4;
    localparam int BYTE_IDX_W  = 12;
    localparam int VERSION_W   = 16;
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int TOTAL_W     = $clog2(MAX_LEVELS * MAX_WIDTH * MAX_WIDTH + 1);
    localparam int BIDX_W      = TOTAL_W + 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_GET     = 3'd0;
    localparam logic [OP_W-1:0] OP_SET     = 3'd1;
    localparam logic [OP_W-1:0] OP_CLR_BIT = 3'd2;
    localparam logic [OP_W-1:0] OP_CLR_ALL = 3'd3;
    localparam logic [OP_W-1:0] OP_MERGE   = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COARSEST_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_VERSION = 2'd2;

    typedef enum logic [2:0] {
        K_NONE,
        K_GET,
        K_SET,
        K_CLR,
        K_CLR_ALL,
        K_MERGE
    } kind_t;

    // Decoded access, held between the read and the write-back cycle
    typedef struct packed {
        kind_t                 kind;
        logic                  ok;
        logic [2:0]            bit_sel;
        logic [STORE_AW-1:0]   addr;
        logic [7:0]            merge_data;
        logic                  count_inc;
    } cmd_t;

    function automatic logic [SIDE_W-1:0] clamp_width(input logic [SIDE_W-1:0] w);
        return (w > SIDE_W'(MAX_WIDTH)) ? SIDE_W'(MAX_WIDTH) : w;
    endfunction

    function automatic logic [LEVEL_W-1:0] clamp_levels(input logic [LEVEL_W-1:0] l);
        return (l > LEVEL_W'(MAX_LEVELS - 1)) ? LEVEL_W'(MAX_LEVELS - 1) : l;
    endfunction

    function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0]  pw,
                                                  input logic [LEVEL_W-1:0] l);
        logic [SIDE_W-1:0] s;
        s = pw >> l;
        return (s == '0) ? SIDE_W'(1) : s;
    endfunction

endpackage

[rtl/mpsb_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module mpsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/mip_pyramid_seen_bitmap_core.sv]
// Top level of the mip pyramid seen bitmap: decode, read-modify-write control,
// clearing pass and level table. Depends on mpsb_pkg and mpsb_ram.
//
// One seen bit per page at each level of a square mip pyramid, packed eight to
// a byte in a 4096 x 8 synchronous RAM, level 0 first, row-major. Each item
// passes a locate state, which finds the bit (level offset plus y*side plus x)
// and issues the RAM read, and then a write-back state, which merges the read
// byte and writes it back while the result beat is loaded into the output
// register; the next item is taken in that same write-back cycle as long as
// the output side takes its beats. The output register holds one result, so
// a stalled output stops the block in write-back. A clear-all item delivers
// its beat at once and then runs a clearing pass over all 4096 bytes (one RAM
// byte per cycle) with the input stalled. Reset and every write to a defined
// register start the same pass; at its start the level offset table and the
// used byte count are rebuilt, one level per cycle. Configuration writes are
// always ready and are meant to be issued only while the block is idle; a
// write to an index past the register list is ignored.
module mip_pyramid_seen_bitmap_core (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mpsb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mpsb_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [mpsb_pkg::OP_W-1:0]            op,
    input  logic signed [mpsb_pkg::LVL_IN_W-1:0] level,
    input  logic signed [mpsb_pkg::COORD_W-1:0]  x,
    input  logic signed [mpsb_pkg::COORD_W-1:0]  y,
    input  logic [mpsb_pkg::BYTE_IDX_W-1:0]      byte_index,
    input  logic [7:0]                           source_byte,
    input  logic [mpsb_pkg::SIDE_W-1:0]          source_width,
    input  logic [mpsb_pkg::LEVEL_W-1:0]         source_levels,
    input  logic [mpsb_pkg::VERSION_W-1:0]       source_version,
    input  logic                                 merge_last,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 bit_value,
    output logic                                 index_valid,
    output logic [mpsb_pkg::COUNT_W-1:0]         merge_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_WRITE,
        S_SWEEP
    } state_t;

    state_t state_reg;

    // Accepted item
    logic [mpsb_pkg::OP_W-1:0]            op_reg;
    logic signed [mpsb_pkg::LVL_IN_W-1:0] level_reg;
    logic signed [mpsb_pkg::COORD_W-1:0]  x_reg;
    logic signed [mpsb_pkg::COORD_W-1:0]  y_reg;
    logic [mpsb_pkg::BYTE_IDX_W-1:0]      bi_reg;
    logic [7:0]                           sb_reg;
    logic [mpsb_pkg::SIDE_W-1:0]          sw_reg;
    logic [mpsb_pkg::LEVEL_W-1:0]         sl_reg;
    logic [mpsb_pkg::VERSION_W-1:0]       sv_reg;
    logic                                 last_reg;

    // Configuration
    logic [mpsb_pkg::SIDE_W-1:0]          page_width_reg;
    logic [mpsb_pkg::LEVEL_W-1:0]         coarsest_reg;
    logic [mpsb_pkg::VERSION_W-1:0]       version_reg;

    // Level table and its rebuild sequencer
    logic [mpsb_pkg::TOTAL_W-1:0]         off_reg [mpsb_pkg::MAX_LEVELS];
    logic [mpsb_pkg::UB_W-1:0]            used_bytes_reg;
    logic                                 rb_busy_reg;
    logic [mpsb_pkg::LEVEL_W-1:0]         rb_lvl_reg;
    logic [mpsb_pkg::TOTAL_W-1:0]         rb_total_reg;

    logic [mpsb_pkg::STORE_AW-1:0]        sweep_cnt_reg;
    logic [mpsb_pkg::COUNT_W-1:0]         merge_cnt_reg;
    mpsb_pkg::cmd_t                       cmd_reg;

    logic                                 out_valid_reg;
    logic                                 bit_value_reg;
    logic                                 index_valid_reg;
    logic [mpsb_pkg::COUNT_W-1:0]         out_count_reg;

    // Handshake
    logic in_accept;
    logic out_free;
    logic proceed;
    logic cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || !out_stall;
    assign proceed   = (state_reg == S_WRITE) && out_free;
    // Take the next beat when idle, or in write-back when the result leaves
    // and no clearing pass follows.
    assign in_stall  = !((state_reg == S_IDLE) ||
                         (proceed && (cmd_reg.kind != mpsb_pkg::K_CLR_ALL)));
    assign in_accept = in_valid && !in_stall;

    // Locate the addressed bit
    logic                                 lvl_ok;
    logic [mpsb_pkg::LEVEL_W-1:0]         lvl_idx;
    logic [mpsb_pkg::SIDE_W-1:0]          side;
    logic                                 x_ok;
    logic                                 y_ok;
    logic [2*mpsb_pkg::SIDE_W-1:0]        prod;
    logic [mpsb_pkg::BIDX_W-1:0]          bidx;
    logic                                 loc_ok;
    logic                                 layout_match;
    mpsb_pkg::cmd_t                       cmd_next;

    always_comb
    begin
        lvl_ok  = !level_reg[mpsb_pkg::LVL_IN_W-1] &&
                  (level_reg[mpsb_pkg::LVL_IN_W-2:0] <=
                   (mpsb_pkg::LVL_IN_W-1)'(coarsest_reg));
        lvl_idx = level_reg[mpsb_pkg::LEVEL_W-1:0];
        side    = mpsb_pkg::side_of(page_width_reg, lvl_idx);
        x_ok    = !x_reg[mpsb_pkg::COORD_W-1] &&
                  (x_reg[mpsb_pkg::COORD_W-2:0] < (mpsb_pkg::COORD_W-1)'(side));
        y_ok    = !y_reg[mpsb_pkg::COORD_W-1] &&
                  (y_reg[mpsb_pkg::COORD_W-2:0] < (mpsb_pkg::COORD_W-1)'(side));
        prod    = y_reg[mpsb_pkg::SIDE_W-1:0] * side;
        bidx    = mpsb_pkg::BIDX_W'(off_reg[lvl_idx]) + mpsb_pkg::BIDX_W'(prod) +
                  mpsb_pkg::BIDX_W'(x_reg[mpsb_pkg::SIDE_W-1:0]);
        loc_ok  = lvl_ok && x_ok && y_ok &&
                  (bidx < mpsb_pkg::BIDX_W'(mpsb_pkg::MAX_BITS)) &&
                  ((bidx >> 3) < mpsb_pkg::BIDX_W'(used_bytes_reg));

        layout_match = (mpsb_pkg::clamp_width(sw_reg) == page_width_reg) &&
                       (mpsb_pkg::clamp_levels(sl_reg) == coarsest_reg) &&
                       (sv_reg == version_reg);

        cmd_next            = '0;
        cmd_next.kind       = mpsb_pkg::K_NONE;
        cmd_next.bit_sel    = bidx[2:0];
        cmd_next.addr       = bidx[mpsb_pkg::BIT_W-1:3];
        cmd_next.merge_data = sb_reg;
        unique case (op_reg)
            mpsb_pkg::OP_GET:
            begin
                cmd_next.kind = mpsb_pkg::K_GET;
                cmd_next.ok   = loc_ok;
            end
            mpsb_pkg::OP_SET:
            begin
                cmd_next.kind = mpsb_pkg::K_SET;
                cmd_next.ok   = loc_ok;
            end
            mpsb_pkg::OP_CLR_BIT:
            begin
                cmd_next.kind = mpsb_pkg::K_CLR;
                cmd_next.ok   = loc_ok;
            end
            mpsb_pkg::OP_CLR_ALL:
            begin
                cmd_next.kind = mpsb_pkg::K_CLR_ALL;
                cmd_next.ok   = 1'b1;
            end
            mpsb_pkg::OP_MERGE:
            begin
                cmd_next.kind      = mpsb_pkg::K_MERGE;
                cmd_next.addr      = mpsb_pkg::STORE_AW'(bi_reg);
                cmd_next.ok        = layout_match &&
                                     ({1'b0, bi_reg} < (mpsb_pkg::BYTE_IDX_W+1)'(used_bytes_reg));
                cmd_next.count_inc = layout_match && last_reg;
            end
            default:
            begin
                cmd_next.kind = mpsb_pkg::K_NONE;
            end
        endcase
    end

    // Store RAM and write-back
    logic                          ram_we;
    logic [mpsb_pkg::STORE_AW-1:0] ram_waddr;
    logic [7:0]                    ram_wdata;
    logic [7:0]                    ram_rdata;
    logic [7:0]                    bit_mask;
    logic                          rmw_we;
    logic [7:0]                    rmw_data;
    logic [mpsb_pkg::COUNT_W-1:0]  count_next;

    always_comb
    begin
        bit_mask = 8'd1 << cmd_reg.bit_sel;
        rmw_we   = 1'b0;
        rmw_data = ram_rdata;
        case (cmd_reg.kind)
            mpsb_pkg::K_SET:
            begin
                rmw_we   = cmd_reg.ok;
                rmw_data = ram_rdata | bit_mask;
            end
            mpsb_pkg::K_CLR:
            begin
                rmw_we   = cmd_reg.ok;
                rmw_data = ram_rdata & ~bit_mask;
            end
            mpsb_pkg::K_MERGE:
            begin
                rmw_we   = cmd_reg.ok;
                rmw_data = ram_rdata | cmd_reg.merge_data;
            end
            default:
            begin
                rmw_we = 1'b0;
            end
        endcase

        if (state_reg == S_SWEEP)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = proceed && rmw_we;
            ram_waddr = cmd_reg.addr;
            ram_wdata = rmw_data;
        end

        if (cmd_reg.kind == mpsb_pkg::K_CLR_ALL)
        begin
            count_next = '0;
        end
        else if (cmd_reg.count_inc)
        begin
            count_next = merge_cnt_reg + mpsb_pkg::COUNT_W'(1);
        end
        else
        begin
            count_next = merge_cnt_reg;
        end
    end

    mpsb_ram #(
        .WIDTH (8),
        .DEPTH (mpsb_pkg::STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cmd_next.addr),
        .rdata (ram_rdata)
    );

    // Level table rebuild: one level per cycle
    logic [mpsb_pkg::SIDE_W-1:0]   rb_side;
    logic [2*mpsb_pkg::SIDE_W-1:0] rb_sq;
    logic                          rb_in;
    logic [mpsb_pkg::TOTAL_W-1:0]  rb_total_next;
    logic [mpsb_pkg::TOTAL_W:0]    ub_sum;
    logic [mpsb_pkg::UB_W-1:0]     ub_next;

    always_comb
    begin
        rb_side       = mpsb_pkg::side_of(page_width_reg, rb_lvl_reg);
        rb_sq         = rb_side * rb_side;
        rb_in         = rb_lvl_reg <= coarsest_reg;
        rb_total_next = rb_total_reg + (rb_in ? mpsb_pkg::TOTAL_W'(rb_sq) : '0);
        ub_sum        = {1'b0, rb_total_next} + (mpsb_pkg::TOTAL_W+1)'(7);
        ub_next       = (ub_sum[mpsb_pkg::TOTAL_W:3] >
                         (mpsb_pkg::TOTAL_W-2)'(mpsb_pkg::STORE_BYTES)) ?
                        mpsb_pkg::UB_W'(mpsb_pkg::STORE_BYTES) :
                        mpsb_pkg::UB_W'(ub_sum[mpsb_pkg::TOTAL_W:3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_SWEEP;
            op_reg          <= '0;
            level_reg       <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            bi_reg          <= '0;
            sb_reg          <= '0;
            sw_reg          <= '0;
            sl_reg          <= '0;
            sv_reg          <= '0;
            last_reg        <= 1'b0;
            page_width_reg  <= '0;
            coarsest_reg    <= '0;
            version_reg     <= '0;
            for (int i = 0; i < mpsb_pkg::MAX_LEVELS; i++)
            begin
                off_reg[i] <= '0;
            end
            used_bytes_reg  <= '0;
            rb_busy_reg     <= 1'b1;
            rb_lvl_reg      <= '0;
            rb_total_reg    <= '0;
            sweep_cnt_reg   <= '0;
            merge_cnt_reg   <= '0;
            cmd_reg         <= '0;
            out_valid_reg   <= 1'b0;
            bit_value_reg   <= 1'b0;
            index_valid_reg <= 1'b0;
            out_count_reg   <= '0;
        end
        else
        begin
            // Drop the result once the beat is taken
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_accept)
            begin
                op_reg    <= op;
                level_reg <= level;
                x_reg     <= x;
                y_reg     <= y;
                bi_reg    <= byte_index;
                sb_reg    <= source_byte;
                sw_reg    <= source_width;
                sl_reg    <= source_levels;
                sv_reg    <= source_version;
                last_reg  <= merge_last;
            end

            if (rb_busy_reg)
            begin
                off_reg[rb_lvl_reg] <= rb_in ? rb_total_reg : '0;
                rb_total_reg        <= rb_total_next;
                rb_lvl_reg          <= rb_lvl_reg + mpsb_pkg::LEVEL_W'(1);
                if (rb_lvl_reg == mpsb_pkg::LEVEL_W'(mpsb_pkg::MAX_LEVELS - 1))
                begin
                    rb_busy_reg    <= 1'b0;
                    used_bytes_reg <= ub_next;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    cmd_reg   <= cmd_next;
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    if (proceed)
                    begin
                        out_valid_reg   <= 1'b1;
                        bit_value_reg   <= (cmd_reg.kind == mpsb_pkg::K_GET) && cmd_reg.ok &&
                                           ram_rdata[cmd_reg.bit_sel];
                        index_valid_reg <= cmd_reg.ok;
                        out_count_reg   <= count_next;
                        merge_cnt_reg   <= count_next;
                        if (cmd_reg.kind == mpsb_pkg::K_CLR_ALL)
                        begin
                            state_reg     <= S_SWEEP;
                            sweep_cnt_reg <= '0;
                        end
                        else if (in_accept)
                        begin
                            state_reg <= S_CALC;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_SWEEP:
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + mpsb_pkg::STORE_AW'(1);
                    if (sweep_cnt_reg == mpsb_pkg::STORE_AW'(mpsb_pkg::STORE_BYTES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Any write to a defined register rebuilds the table and clears the store
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    mpsb_pkg::REG_PAGE_WIDTH:
                    begin
                        page_width_reg <= mpsb_pkg::clamp_width(cfg_data[mpsb_pkg::SIDE_W-1:0]);
                    end
                    mpsb_pkg::REG_COARSEST_LEVEL:
                    begin
                        coarsest_reg <= mpsb_pkg::clamp_levels(cfg_data[mpsb_pkg::LEVEL_W-1:0]);
                    end
                    mpsb_pkg::REG_LAYOUT_VERSION:
                    begin
                        version_reg <= cfg_data[mpsb_pkg::VERSION_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
                if (cfg_index == mpsb_pkg::REG_PAGE_WIDTH ||
                    cfg_index == mpsb_pkg::REG_COARSEST_LEVEL ||
                    cfg_index == mpsb_pkg::REG_LAYOUT_VERSION)
                begin
                    state_reg     <= S_SWEEP;
                    sweep_cnt_reg <= '0;
                    rb_busy_reg   <= 1'b1;
                    rb_lvl_reg    <= '0;
                    rb_total_reg  <= '0;
                    merge_cnt_reg <= '0;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign bit_value   = bit_value_reg;
    assign index_valid = index_valid_reg;
    assign merge_count = out_count_reg;

    // Checks
    a_sweep_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> in_stall)
        else $error("input taken during clearing pass");

    a_sweep_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (ram_we && (ram_wdata == 8'd0)))
        else $error("clearing pass not writing zero");

    a_calc_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |-> !ram_we)
        else $error("store written while the read is in flight");

    a_bit_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bit_value_reg) |-> index_valid_reg)
        else $error("bit value set on an invalid access");

    a_clear_all_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && (cmd_reg.kind == mpsb_pkg::K_CLR_ALL)) |=>
        ((state_reg == S_SWEEP) && (merge_cnt_reg == '0) && (sweep_cnt_reg == '0)))
        else $error("clear all did not start a clearing pass");

endmodule

[tb/sv/mpsb_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the mip pyramid seen bitmap core: follows register writes and
// input beats, predicts every result beat and compares it. Depends on mpsb_pkg.
module mpsb_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [mpsb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mpsb_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [mpsb_pkg::OP_W-1:0]            op,
    input  logic signed [mpsb_pkg::LVL_IN_W-1:0] level,
    input  logic signed [mpsb_pkg::COORD_W-1:0]  x,
    input  logic signed [mpsb_pkg::COORD_W-1:0]  y,
    input  logic [mpsb_pkg::BYTE_IDX_W-1:0]      byte_index,
    input  logic [7:0]                           source_byte,
    input  logic [mpsb_pkg::SIDE_W-1:0]          source_width,
    input  logic [mpsb_pkg::LEVEL_W-1:0]         source_levels,
    input  logic [mpsb_pkg::VERSION_W-1:0]       source_version,
    input  logic                                 merge_last,

    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic                                 bit_value,
    input  logic                                 index_valid,
    input  logic [mpsb_pkg::COUNT_W-1:0]         merge_count,

    output int                                   mismatches,
    output int                                   pending
);
    import mpsb_pkg::*;

    typedef struct packed {
        logic               bit_value;
        logic               index_valid;
        logic [COUNT_W-1:0] merge_count;
    } seen_beat_t;

    seen_beat_t           expected_q [$];
    logic [7:0]           page_bytes [STORE_BYTES];
    int unsigned          level_base [MAX_LEVELS];
    int unsigned          live_bytes;
    logic [COUNT_W-1:0]   merges_done;
    logic [SIDE_W-1:0]    width_reg;
    logic [LEVEL_W-1:0]   top_level_reg;
    logic [VERSION_W-1:0] version_reg;

    function automatic int unsigned fit_width(input int unsigned w);
        if (w > MAX_WIDTH)
            return MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned fit_levels(input int unsigned l);
        if (l > MAX_LEVELS - 1)
            return MAX_LEVELS - 1;
        return l;
    endfunction

    function automatic int unsigned side_at(input int unsigned lvl);
        int unsigned s;
        s = (lvl < 32) ? (int'(width_reg) >> lvl) : 0;
        return (s == 0) ? 1 : s;
    endfunction

    // Lay the levels out back to back and wipe the store and the merge count.
    function automatic void relayout();
        longint unsigned total;
        longint unsigned s;
        total = 0;
        foreach (level_base[i])
            level_base[i] = 0;
        for (int lvl = 0; lvl <= int'(top_level_reg); lvl++) begin
            s = side_at(lvl);
            level_base[lvl] = 32'(total);
            total += s * s;
        end
        live_bytes = (((total + 7) >> 3) > STORE_BYTES) ? STORE_BYTES : 32'((total + 7) >> 3);
        foreach (page_bytes[i])
            page_bytes[i] = '0;
        merges_done = '0;
    endfunction

    function automatic bit find_bit(input int lvl, input int px, input int py,
                                    output int unsigned idx);
        int unsigned     s;
        longint unsigned b;
        idx = 0;
        if (lvl < 0 || lvl > int'(top_level_reg))
            return 1'b0;
        s = side_at(lvl);
        if (px < 0 || py < 0 || px >= int'(s) || py >= int'(s))
            return 1'b0;
        b = 64'(level_base[lvl]) + 64'(py) * 64'(s) + 64'(px);
        if (b >= MAX_BITS || (b >> 3) >= live_bytes)
            return 1'b0;
        idx = 32'(b);
        return 1'b1;
    endfunction

    function automatic seen_beat_t apply_access(
        input logic [OP_W-1:0]      code,
        input int                   lvl,
        input int                   px,
        input int                   py,
        input int unsigned          bidx,
        input logic [7:0]           src,
        input int unsigned          sw,
        input int unsigned          sl,
        input logic [VERSION_W-1:0] sv,
        input logic                 last
    );
        seen_beat_t  r;
        int unsigned idx;
        r = '0;
        case (code)
            OP_GET, OP_SET, OP_CLR_BIT: begin
                if (find_bit(lvl, px, py, idx)) begin
                    r.index_valid = 1'b1;
                    if (code == OP_GET)
                        r.bit_value = page_bytes[idx >> 3][idx % 8];
                    else if (code == OP_SET)
                        page_bytes[idx >> 3][idx % 8] = 1'b1;
                    else
                        page_bytes[idx >> 3][idx % 8] = 1'b0;
                end
            end
            OP_CLR_ALL: begin
                foreach (page_bytes[i])
                    page_bytes[i] = '0;
                merges_done   = '0;
                r.index_valid = 1'b1;
            end
            OP_MERGE: begin
                if (fit_width(sw) == width_reg && fit_levels(sl) == top_level_reg &&
                    sv == version_reg) begin
                    if (bidx < live_bytes) begin
                        page_bytes[bidx] = page_bytes[bidx] | src;
                        r.index_valid    = 1'b1;
                    end
                    if (last)
                        merges_done = merges_done + 1'b1;
                end
            end
            default: ;
        endcase
        r.merge_count = merges_done;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : track_beats
        seen_beat_t exp_beat;
        seen_beat_t got_beat;
        if (!rst_n) begin
            width_reg     = '0;
            top_level_reg = '0;
            version_reg   = '0;
            relayout();
            expected_q.delete();
            mismatches    = 0;
            pending      <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PAGE_WIDTH: begin
                        width_reg = SIDE_W'(fit_width(cfg_data[SIDE_W-1:0]));
                        relayout();
                    end
                    REG_COARSEST_LEVEL: begin
                        top_level_reg = LEVEL_W'(fit_levels(cfg_data[LEVEL_W-1:0]));
                        relayout();
                    end
                    REG_LAYOUT_VERSION: begin
                        version_reg = cfg_data[VERSION_W-1:0];
                        relayout();
                    end
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_q.push_back(apply_access(op, int'(level), int'(x), int'(y),
                                                  byte_index, source_byte, source_width,
                                                  source_levels, source_version,
                                                  merge_last));
            if (out_valid && !out_stall) begin
                got_beat = {bit_value, index_valid, merge_count};
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: unexpected beat bit_value=%0b index_valid=%0b merge_count=%0d",
                                 bit_value, index_valid, merge_count);
                end else begin
                    exp_beat = expected_q.pop_front();
                    if (got_beat !== exp_beat) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: bit_value %0b/%0b index_valid %0b/%0b merge_count %0d/%0d (expected/actual)",
                                     exp_beat.bit_value, bit_value,
                                     exp_beat.index_valid, index_valid,
                                     exp_beat.merge_count, merge_count);
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

[tb/sv/tb_mip_pyramid_seen_bitmap_core.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the mip pyramid seen bitmap core. Depends on mpsb_pkg,
// the core RTL and mpsb_checker, which predicts and compares every result beat.
module tb_mip_pyramid_seen_bitmap_core;
    import mpsb_pkg::*;

    // The core wipes its RAM after reset, after every write to a defined register
    // and after a clear-all beat; hold off until that wipe is done.
    localparam int SETTLE_CYCLES = 4200;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 172;

    // Op codes past the defined set; the core must treat them as no-ops
    localparam logic [OP_W-1:0]      OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0]      OP_UNUSED_HI = 3'd7;
    // Register index past the list; a write there is dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;

    typedef struct {
        logic [OP_W-1:0]            op;
        logic signed [LVL_IN_W-1:0] level;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [BYTE_IDX_W-1:0]      bi;
        logic [7:0]                 sb;
        logic [SIDE_W-1:0]          sw;
        logic [LEVEL_W-1:0]         sl;
        logic [VERSION_W-1:0]       sv;
        logic                       last;
    } seen_req_t;

    logic                       clk            = 1'b0;
    logic                       rst_n          = 1'b0;
    logic                       cfg_valid      = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index      = '0;
    logic [CFG_DATA_W-1:0]      cfg_data       = '0;
    logic                       in_valid       = 1'b0;
    logic                       in_stall;
    logic [OP_W-1:0]            op             = '0;
    logic signed [LVL_IN_W-1:0] level          = '0;
    logic signed [COORD_W-1:0]  x              = '0;
    logic signed [COORD_W-1:0]  y              = '0;
    logic [BYTE_IDX_W-1:0]      byte_index     = '0;
    logic [7:0]                 source_byte    = '0;
    logic [SIDE_W-1:0]          source_width   = '0;
    logic [LEVEL_W-1:0]         source_levels  = '0;
    logic [VERSION_W-1:0]       source_version = '0;
    logic                       merge_last     = 1'b0;
    logic                       out_valid;
    logic                       out_stall      = 1'b0;
    logic                       bit_value;
    logic                       index_valid;
    logic [COUNT_W-1:0]         merge_count;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int stall_left  = 0;
    int stall_pick;

    // Layout currently programmed, as the stimulus side sees it; used to aim
    // coordinates and merge bytes at the live part of the store.
    int unsigned          cur_width   = 0;
    int unsigned          cur_top     = 0;
    int unsigned          used_span   = 1;
    logic [VERSION_W-1:0] cur_version = '0;

    mip_pyramid_seen_bitmap_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .level          (level),
        .x              (x),
        .y              (y),
        .byte_index     (byte_index),
        .source_byte    (source_byte),
        .source_width   (source_width),
        .source_levels  (source_levels),
        .source_version (source_version),
        .merge_last     (merge_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bit_value      (bit_value),
        .index_valid    (index_valid),
        .merge_count    (merge_count)
    );

    mpsb_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .level          (level),
        .x              (x),
        .y              (y),
        .byte_index     (byte_index),
        .source_byte    (source_byte),
        .source_width   (source_width),
        .source_levels  (source_levels),
        .source_version (source_version),
        .merge_last     (merge_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bit_value      (bit_value),
        .index_valid    (index_valid),
        .merge_count    (merge_count),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    // 2 ns clock, first rising edge at 1 ns
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: end the run if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side back-pressure: mostly short stalls and short free runs,
    // now and then a long stall, and long stretches with no stall at all.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 50)
            begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 6);
            end
            else if (stall_pick < 85)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else if (stall_pick < 95)
            begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(20, 80);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    // Idle cycles after an input beat: usually none, sometimes a few, rarely many
    function automatic int unsigned pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Fill every field but the op (set to GET) with noise; callers then overwrite what the op uses
    function automatic seen_req_t noise_req();
        seen_req_t r;
        r.op    = OP_GET;
        r.level = LVL_IN_W'($urandom);
        r.x     = COORD_W'($urandom);
        r.y     = COORD_W'($urandom);
        r.bi    = BYTE_IDX_W'($urandom);
        r.sb    = 8'($urandom);
        r.sw    = SIDE_W'($urandom_range(0, MAX_WIDTH));
        r.sl    = LEVEL_W'($urandom);
        r.sv    = VERSION_W'($urandom);
        r.last  = 1'($urandom);
        return r;
    endfunction

    function automatic seen_req_t coord_req(input logic [OP_W-1:0] code, input int lvl,
                                            input int px, input int py);
        seen_req_t r;
        r       = noise_req();
        r.op    = code;
        r.level = LVL_IN_W'(lvl);
        r.x     = COORD_W'(px);
        r.y     = COORD_W'(py);
        return r;
    endfunction

    function automatic seen_req_t merge_req(input int unsigned bidx, input logic [7:0] src,
                                            input int unsigned sw, input int unsigned sl,
                                            input logic [VERSION_W-1:0] sv,
                                            input logic last);
        seen_req_t r;
        r      = noise_req();
        r.op   = OP_MERGE;
        r.bi   = BYTE_IDX_W'(bidx);
        r.sb   = src;
        r.sw   = SIDE_W'(sw);
        r.sl   = LEVEL_W'(sl);
        r.sv   = sv;
        r.last = last;
        return r;
    endfunction

    // Random item aimed at the live layout: most coordinates land inside the
    // pyramid, most merges carry the programmed layout, the rest is noise.
    function automatic seen_req_t rand_req();
        seen_req_t   r;
        int          pick_op;
        int unsigned lvl;
        int unsigned s;
        r       = noise_req();
        pick_op = $urandom_range(0, 999);
        if (pick_op < 350)
            r.op = OP_GET;
        else if (pick_op < 600)
            r.op = OP_SET;
        else if (pick_op < 750)
            r.op = OP_CLR_BIT;
        else if (pick_op < 970)
            r.op = OP_MERGE;
        else if (pick_op < 980)
            r.op = OP_CLR_ALL;
        else
            r.op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));

        if (r.op == OP_MERGE)
        begin
            r.sw = SIDE_W'(cur_width);
            r.sl = LEVEL_W'(cur_top);
            r.sv = cur_version;
            // break one layout field now and then
            case ($urandom_range(0, 9))
                0:       r.sw = SIDE_W'($urandom_range(0, MAX_WIDTH));
                1:       r.sl = LEVEL_W'($urandom);
                2:       r.sv = VERSION_W'($urandom);
                default: ;
            endcase
            if ($urandom_range(0, 3) != 0)
                r.bi = BYTE_IDX_W'($urandom_range(0, used_span - 1));
            r.last = ($urandom_range(0, 9) < 3);
        end
        else if ($urandom_range(0, 99) < 85)
        begin
            lvl = $urandom_range(0, cur_top);
            s   = cur_width >> lvl;
            if (s == 0)
                s = 1;
            r.level = LVL_IN_W'(lvl);
            r.x     = COORD_W'($urandom_range(0, s - 1));
            r.y     = COORD_W'($urandom_range(0, s - 1));
            // step just past an edge of the level, or one level too far
            case ($urandom_range(0, 29))
                0:       r.x     = COORD_W'(s);
                1:       r.y     = COORD_W'(s);
                2:       r.level = LVL_IN_W'(cur_top + 1);
                default: ;
            endcase
        end
        return r;
    endfunction

    // Drive one input beat and hold it until the core takes it
    task automatic push_req(input seen_req_t r);
        int unsigned gap;
        op             <= r.op;
        level          <= r.level;
        x              <= r.x;
        y              <= r.y;
        byte_index     <= r.bi;
        source_byte    <= r.sb;
        source_width   <= r.sw;
        source_levels  <= r.sl;
        source_version <= r.sv;
        merge_last     <= r.last;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        gap = pick_gap();
        // drop valid only when a gap follows, so back-to-back beats keep it high
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid, let every result beat come back, then let any clearing pass finish.
    // Step past a clock edge first so the pending count covers the last beat taken.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write beat; a write to a defined register makes the core wipe its store, so hold off after it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Program a new layout once the core is idle, and note its live byte count
    task automatic set_layout(input int unsigned w, input int unsigned t,
                              input logic [VERSION_W-1:0] v, input bit poke_spare);
        longint unsigned total;
        int unsigned     s;
        wait_quiet();
        if (poke_spare)
            write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        write_reg(REG_PAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_COARSEST_LEVEL, CFG_DATA_W'(t));
        write_reg(REG_LAYOUT_VERSION, v);
        cur_width   = w;
        cur_top     = t;
        cur_version = v;
        total       = 0;
        for (int lvl = 0; lvl <= int'(t); lvl++)
        begin
            s = w >> lvl;
            if (s == 0)
                s = 1;
            total += s * s;
        end
        used_span = (((total + 7) >> 3) > STORE_BYTES) ? STORE_BYTES : 32'((total + 7) >> 3);
    endtask

    initial
    begin : stimulus
        int unsigned          widths   [RANDOM_PHASES];
        int unsigned          tops     [RANDOM_PHASES];
        logic [VERSION_W-1:0] versions [RANDOM_PHASES];

        widths   = '{0, 128, 1, 5, 16, 128, 3, 2, 37};
        tops     = '{0, 15, 15, 2, 15, 0, 1, 3, 6};
        versions = '{16'h0000, 16'hFFFF, 16'h0001, 16'h1234, VERSION_W'($urandom),
                     VERSION_W'($urandom), 16'h8000, VERSION_W'($urandom),
                     VERSION_W'($urandom)};

        // Hold reset at the start, once
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on an 8-page pyramid with 5 levels (86 bits, 11 bytes)
        set_layout(8, 4, 16'hA5C3, 1'b0);

        // single bits at both corners of the finest level
        push_req(coord_req(OP_SET, 0, 0, 0));
        push_req(coord_req(OP_GET, 0, 0, 0));
        push_req(coord_req(OP_SET, 0, 7, 7));
        push_req(coord_req(OP_GET, 0, 7, 7));
        push_req(coord_req(OP_CLR_BIT, 0, 0, 0));
        push_req(coord_req(OP_GET, 0, 0, 0));
        // coarsest level, one page wide
        push_req(coord_req(OP_SET, 4, 0, 0));
        push_req(coord_req(OP_GET, 4, 0, 0));
        // out-of-range coordinates: level too high or negative, extremes of x and y,
        // x or y equal to the side
        push_req(coord_req(OP_SET, 5, 0, 0));
        push_req(coord_req(OP_GET, -1, 0, 0));
        push_req(coord_req(OP_GET, -32, 255, -256));
        push_req(coord_req(OP_SET, 31, -1, 255));
        push_req(coord_req(OP_SET, 0, 8, 0));
        push_req(coord_req(OP_CLR_BIT, 1, 0, 4));
        // merges: first and last live byte, byte just past the live area (still counts),
        // far end of the index, then each layout field wrong
        push_req(merge_req(0, 8'hFF, 8, 4, 16'hA5C3, 1'b0));
        push_req(merge_req(10, 8'h81, 8, 4, 16'hA5C3, 1'b1));
        push_req(merge_req(11, 8'hFF, 8, 4, 16'hA5C3, 1'b1));
        push_req(merge_req(4095, 8'h5A, 8, 4, 16'hA5C3, 1'b0));
        push_req(merge_req(1, 8'hFF, 8, 4, 16'h5A3C, 1'b1));
        push_req(merge_req(1, 8'hFF, 128, 4, 16'hA5C3, 1'b1));
        push_req(merge_req(1, 8'hFF, 8, 15, 16'hA5C3, 1'b1));
        push_req(coord_req(OP_GET, 0, 1, 0));
        // clear all wipes bits and the merge count
        push_req(coord_req(OP_CLR_ALL, 0, 0, 0));
        push_req(coord_req(OP_GET, 0, 7, 7));
        // undefined op codes
        push_req(coord_req(OP_UNUSED_LO, 0, 0, 0));
        push_req(coord_req(OP_UNUSED_HI, 0, 0, 0));

        // Random part across layouts, extremes included; one phase also pokes
        // the unused register index
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_layout(widths[p], tops[p], versions[p], p == 3);
            repeat (PHASE_ITEMS) push_req(rand_req());
        end

        // Drain: step past a clock edge so the last beat is counted, wait for every
        // expected beat, then a short tail for strays
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
